### src/rdc_pkg.sv
// Package for the radix digit converter.
// Holds the controller state type, field widths and the radix saturation function.
// No dependencies.
package rdc_pkg;

    localparam int RADIX_W = 5;
    localparam int DIGIT_W = 4;
    localparam int REM_W   = 4;

    localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;
    localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_READ,
        ST_LOAD,
        ST_SEND
    } rdc_state_t;

    // Register values below two act as two, values above sixteen act as sixteen.
    function automatic logic [RADIX_W-1:0] eff_radix(input logic [RADIX_W-1:0] r);
        logic [RADIX_W-1:0] res;
        begin
            res = r;
            if (r < RADIX_MIN) begin
                res = RADIX_MIN;
            end else if (r > RADIX_MAX) begin
                res = RADIX_MAX;
            end
            return res;
        end
    endfunction

endpackage

### src/rdc_serial_divider.sv
// Bit-serial restoring divider: one quotient bit per cycle.
// Divides a VALUE_BITS-wide dividend by a radix of 2 to 16.
// Depends on rdc_pkg.
module rdc_serial_divider
    import rdc_pkg::*;
#(
    parameter int VALUE_BITS = 31
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [VALUE_BITS-1:0] dividend,
    input  logic [RADIX_W-1:0]    divisor,
    output logic                  done,
    output logic [VALUE_BITS-1:0] quotient,
    output logic [REM_W-1:0]      remainder
);

    localparam int CNT_W = $clog2(VALUE_BITS + 1);

    logic [VALUE_BITS-1:0] quot_reg;
    logic [REM_W-1:0]      rem_reg;
    logic [RADIX_W-1:0]    div_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic                  busy_reg;
    logic                  done_reg;

    logic [RADIX_W-1:0]    trial;
    logic                  fits;
    logic [RADIX_W-1:0]    diff;

    assign trial = {rem_reg, quot_reg[VALUE_BITS-1]};
    assign fits  = (trial >= div_reg);
    assign diff  = trial - div_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(VALUE_BITS);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quot_reg <= dividend;
            rem_reg  <= '0;
            div_reg  <= divisor;
        end else if (busy_reg) begin
            quot_reg <= {quot_reg[VALUE_BITS-2:0], fits};
            rem_reg  <= fits ? diff[REM_W-1:0] : trial[REM_W-1:0];
        end
    end

    assign done      = done_reg;
    assign quotient  = quot_reg;
    assign remainder = rem_reg;

endmodule

### src/rdc_digit_stack.sv
// Digit stack memory: one write port and one registered read port.
// Entries are undefined until written.
// Depends on rdc_pkg.
module rdc_digit_stack
    import rdc_pkg::*;
#(
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DIGIT_W-1:0]       wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [DIGIT_W-1:0]       rd_data
);

    logic [DIGIT_W-1:0] mem [DEPTH];
    logic [DIGIT_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### src/radix_digit_converter_core.sv
// Operation: the serial divider produces the digits least significant first into the stack;
// each digit is then popped (read, load) and sent, most significant first.
// Flow: one value at a time; a new value is taken only in idle. A zero input goes straight
// to the output as a single zero digit, sent when the receiver is ready.
// Reset: synchronous, active low; the radix returns to ten and the controller to idle.
// Depends on rdc_pkg, rdc_serial_divider and rdc_digit_stack.
module radix_digit_converter_core
    import rdc_pkg::*;
#(
    parameter int STACK_DEPTH = 32,
    parameter int VALUE_BITS  = 31
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [VALUE_BITS-1:0] s_value,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [DIGIT_W-1:0]    m_digit,
    output logic                  m_last_digit,
    output logic                  m_empty_result,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [RADIX_W-1:0]    cfg_wdata
);

    localparam int ADDR_W = $clog2(STACK_DEPTH);
    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);

    rdc_state_t           state_reg, state_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [RADIX_W-1:0]   radix_reg;
    logic                 m_valid_reg, m_valid_next;
    logic [DIGIT_W-1:0]   m_digit_reg, m_digit_next;
    logic                 m_last_reg, m_last_next;
    logic                 m_empty_reg, m_empty_next;

    logic                  div_start;
    logic [VALUE_BITS-1:0] div_dividend;
    logic                  div_done;
    logic [VALUE_BITS-1:0] div_quotient;
    logic [REM_W-1:0]      div_remainder;

    logic                  wr_en;
    logic                  rd_en;
    logic [DIGIT_W-1:0]    rd_data;
    logic [CNT_W-1:0]      count_dec;

    assign count_dec = count_reg - CNT_W'(1);

    rdc_serial_divider #(
        .VALUE_BITS(VALUE_BITS)
    ) u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (eff_radix(radix_reg)),
        .done     (div_done),
        .quotient (div_quotient),
        .remainder(div_remainder)
    );

    rdc_digit_stack #(
        .DEPTH(STACK_DEPTH)
    ) u_stack (
        .aclk   (aclk),
        .wr_en  (wr_en),
        .wr_addr(count_reg[ADDR_W-1:0]),
        .wr_data(div_remainder),
        .rd_en  (rd_en),
        .rd_addr(count_dec[ADDR_W-1:0]),
        .rd_data(rd_data)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = (s_value == '0) ? ST_SEND : ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_done && (div_quotient == '0)) begin
                    state_next = ST_READ;
                end
            end
            ST_READ: state_next = ST_LOAD;
            ST_LOAD: state_next = ST_SEND;
            ST_SEND: begin
                if (m_ready) begin
                    state_next = m_last_reg ? ST_IDLE : ST_READ;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready      = 1'b0;
        div_start    = 1'b0;
        div_dividend = div_quotient;
        wr_en        = 1'b0;
        rd_en        = 1'b0;
        count_next   = count_reg;
        m_valid_next = m_valid_reg;
        m_digit_next = m_digit_reg;
        m_last_next  = m_last_reg;
        m_empty_next = m_empty_reg;
        case (state_reg)
            ST_IDLE: begin
                s_ready      = 1'b1;
                div_dividend = s_value;
                count_next   = '0;
                if (s_valid) begin
                    if (s_value == '0) begin
                        m_valid_next = 1'b1;
                        m_digit_next = '0;
                        m_last_next  = 1'b1;
                        m_empty_next = 1'b1;
                    end else begin
                        div_start = 1'b1;
                    end
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    if (count_reg < CNT_W'(STACK_DEPTH)) begin
                        wr_en      = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end
                    if (div_quotient != '0) begin
                        div_start = 1'b1;
                    end
                end
            end
            ST_READ: begin
                rd_en      = 1'b1;
                count_next = count_dec;
            end
            ST_LOAD: begin
                m_valid_next = 1'b1;
                m_digit_next = rd_data;
                m_last_next  = (count_reg == '0);
                m_empty_next = 1'b0;
            end
            ST_SEND: begin
                if (m_ready) begin
                    m_valid_next = 1'b0;
                end
            end
            default: begin
                m_valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
            radix_reg   <= RADIX_RESET;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid) begin
                radix_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        m_digit_reg <= m_digit_next;
        m_last_reg  <= m_last_next;
        m_empty_reg <= m_empty_next;
    end

    assign cfg_ready      = 1'b1;
    assign m_valid        = m_valid_reg;
    assign m_digit        = m_digit_reg;
    assign m_last_digit   = m_last_reg;
    assign m_empty_result = m_empty_reg;

endmodule

### verif/tb_radix_digit_converter_core.sv
`timescale 1ns / 1ps
// Self-checking testbench for radix_digit_converter_core: random values in many bases,
// with a digit predictor checked against every output transfer.
// Depends on rdc_pkg and the converter RTL.
module tb_radix_digit_converter_core;
    import rdc_pkg::*;

    localparam int          VALUE_W      = 31;
    localparam logic [VALUE_W-1:0] VALUE_MAX = '1;
    localparam int unsigned RANDOM_ITEMS = 500;
    localparam int unsigned HOLD_CYCLES  = 3000;
    localparam int unsigned DRAIN_CYCLES = 1200;
    localparam int unsigned CYCLE_LIMIT  = 3_000_000;

    typedef struct packed {
        logic [DIGIT_W-1:0] digit;
        logic               last_digit;
        logic               empty_result;
    } digit_rec_t;

    logic                aclk;
    logic                aresetn   = 1'b0;
    logic                s_valid   = 1'b0;
    logic                s_ready;
    logic [VALUE_W-1:0]  s_value   = '0;
    logic                m_valid;
    logic                m_ready   = 1'b0;
    logic [DIGIT_W-1:0]  m_digit;
    logic                m_last_digit;
    logic                m_empty_result;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [RADIX_W-1:0]  cfg_wdata = '0;

    logic [VALUE_W-1:0]  value_q[$];
    digit_rec_t          pending_digits[$];
    logic [RADIX_W-1:0]  base_reg = RADIX_RESET;

    logic        in_fire  = 1'b0;
    logic        cfg_fire = 1'b0;
    bit          hold_req = 1'b0;
    int unsigned queued_cnt, acc_cnt, digit_cnt, zero_cnt, radix_cnt, err_cnt, cycle_cnt;
    int unsigned burst_left, gap_left, pace_mode, pace_left, hold_left;

    radix_digit_converter_core #(
        .STACK_DEPTH (32),
        .VALUE_BITS  (VALUE_W)
    ) dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_value        (s_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_digit        (m_digit),
        .m_last_digit   (m_last_digit),
        .m_empty_result (m_empty_result),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_wdata      (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic int unsigned clamp_base(input logic [RADIX_W-1:0] r);
        if (r < 2) begin
            return 2;
        end else if (r > 16) begin
            return 16;
        end
        return 32'(r);
    endfunction

    // Pushes the digits of one value, most significant first.
    function automatic void convert_value(input logic [VALUE_W-1:0] val);
        int unsigned        b;
        logic [VALUE_W-1:0] quo;
        logic [DIGIT_W-1:0] stack[$];
        digit_rec_t         rec;
        b = clamp_base(base_reg);
        if (val == 0) begin
            rec.digit        = '0;
            rec.last_digit   = 1'b1;
            rec.empty_result = 1'b1;
            pending_digits.push_back(rec);
            return;
        end
        quo = val;
        while (quo != 0) begin
            stack.push_back(DIGIT_W'(quo % b));
            quo = VALUE_W'(quo / b);
        end
        while (stack.size() > 0) begin
            rec.digit        = stack.pop_back();
            rec.last_digit   = (stack.size() == 0);
            rec.empty_result = 1'b0;
            pending_digits.push_back(rec);
        end
    endfunction

    function automatic logic [VALUE_W-1:0] pick_value(input logic [RADIX_W-1:0] r);
        logic [63:0] p;
        int unsigned b;
        b = clamp_base(r);
        p = 1;
        case ($urandom_range(0, 9))
            0: return '0;
            1, 2: return VALUE_W'($urandom_range(1, 255));
            3, 4: return VALUE_W'($urandom() >> $urandom_range(1, 31));
            5, 6: begin
                // Values around a power of the base flip the digit count.
                repeat ($urandom_range(1, 31)) begin
                    if (p * b < 64'h8000_0000) begin
                        p = p * b;
                    end
                end
                return VALUE_W'(p + $urandom_range(0, 2) - 1);
            end
            default: return VALUE_W'($urandom());
        endcase
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            err_cnt++;
        end
    endfunction

    task automatic offer(input logic [VALUE_W-1:0] val);
        value_q.push_back(val);
        queued_cnt++;
    endtask

    task automatic wait_idle();
        while (acc_cnt != queued_cnt || pending_digits.size() != 0) begin
            @(negedge aclk);
        end
    endtask

    task automatic write_radix(input logic [RADIX_W-1:0] r);
        wait_idle();
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_wdata <= r;
        do @(negedge aclk); while (!cfg_fire);
        cfg_valid <= 1'b0;
        radix_cnt++;
    endtask

    // Sender: bursts of random length separated by random gaps.
    always @(negedge aclk) begin : sender
        logic nxt_valid;
        nxt_valid = s_valid;
        if (s_valid && in_fire) begin
            nxt_valid = 1'b0;
        end
        if (!nxt_valid && aresetn) begin
            if (gap_left > 0) begin
                gap_left--;
            end else if (value_q.size() > 0) begin
                nxt_valid = 1'b1;
                s_value <= value_q.pop_front();
                if (burst_left > 0) begin
                    burst_left--;
                end
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 8);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end
            end
        end
        s_valid <= nxt_valid;
    end

    // Receiver: stall pattern that changes at random times, plus one long hold-off.
    always @(negedge aclk) begin : receiver
        if (pace_left == 0) begin
            pace_mode = $urandom_range(0, 3);
            pace_left = $urandom_range(50, 300);
        end else begin
            pace_left--;
        end
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            case (pace_mode)
                0: m_ready <= 1'b1;
                1: m_ready <= ($urandom_range(0, 3) != 0);
                2: m_ready <= ($urandom_range(0, 3) == 0);
                default: m_ready <= ~m_ready;
            endcase
        end
    end

    always @(posedge aclk) begin : monitor
        digit_rec_t want;
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d digits outstanding.",
                     cycle_cnt, pending_digits.size());
            $display("FAIL radix_digit_converter_core");
            $finish;
        end else begin
            in_fire  <= s_valid && s_ready && aresetn;
            cfg_fire <= cfg_valid && cfg_ready && aresetn;
            if (aresetn) begin
                if (cfg_valid && cfg_ready) begin
                    base_reg = cfg_wdata;
                end
                if (s_valid && s_ready) begin
                    convert_value(s_value);
                    acc_cnt++;
                    if (s_value == 0) begin
                        zero_cnt++;
                    end
                end
                if (m_valid && m_ready) begin
                    digit_cnt++;
                    if (pending_digits.size() == 0) begin
                        $error("Unexpected output transfer: digit %0d", m_digit);
                        err_cnt++;
                    end else begin
                        want = pending_digits.pop_front();
                        check_field("digit", want.digit, m_digit);
                        check_field("last_digit", want.last_digit, m_last_digit);
                        check_field("empty_result", want.empty_result, m_empty_result);
                    end
                end
            end
        end
    end

    initial begin
        logic [RADIX_W-1:0] r;
        int unsigned        n, phase, target;
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed values in the reset base, then at the edges of the radix range.
        offer('0);
        offer(1);
        offer(9);
        offer(10);
        offer(999_999_999);
        offer(VALUE_W'(32'h5555_5555));
        offer(VALUE_W'(32'h2AAA_AAAA));
        offer(VALUE_MAX);
        write_radix(2);
        offer(1);
        offer(VALUE_W'(32'h4000_0000));
        offer(VALUE_MAX);
        write_radix(16);
        offer(15);
        offer(16);
        offer(VALUE_MAX);
        write_radix(0);
        offer(5);
        write_radix(1);
        offer(6);
        write_radix(17);
        offer(255);
        write_radix(31);
        offer(VALUE_MAX);
        write_radix(3);
        offer(VALUE_MAX);

        target = queued_cnt + RANDOM_ITEMS;
        phase  = 0;
        while (queued_cnt < target) begin
            r = ($urandom_range(0, 9) < 8) ? RADIX_W'($urandom_range(2, 16))
                                           : RADIX_W'($urandom_range(0, 31));
            write_radix(r);
            if (phase == 3) begin
                hold_req = 1'b1;
            end
            n = $urandom_range(20, 60);
            repeat (n) begin
                offer(pick_value(r));
            end
            phase++;
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge aclk);
        $display("Converted %0d values (%0d of them zero) into %0d digit transfers.",
                 acc_cnt, zero_cnt, digit_cnt);
        $display("Used %0d radix writes; the receiver held off once for %0d cycles.",
                 radix_cnt, HOLD_CYCLES);
        if (err_cnt == 0) begin
            $display("PASS radix_digit_converter_core");
        end else begin
            $display("FAIL radix_digit_converter_core");
        end
        $finish;
    end

endmodule

### sim.f
src/rdc_pkg.sv
src/rdc_serial_divider.sv
src/rdc_digit_stack.sv
src/radix_digit_converter_core.sv
verif/tb_radix_digit_converter_core.sv
